[hdl/bf3_pkg.sv]
// Shared constants, codes and types of the 3x3 RGB box filter.
`default_nettype none
package bf3_pkg;

   localparam int MAX_WIDTH = 2048;
   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int WIDTH_W = COL_W + 1;
   localparam int FW_W = 12;
   localparam int HEIGHT_W = 16;
   localparam int ROW_W = HEIGHT_W + 1;
   localparam int CSR_DATA_W = 16;

   localparam int CH_W = 8;
   localparam int CH_COUNT = 3;
   localparam int PIX_W = CH_W * CH_COUNT;
   localparam int WIN_COUNT = 9;
   localparam int SUM_W = 12;

   localparam int RECIP_W = 13;
   localparam logic [RECIP_W-1:0] DIV9_RECIP = 13'd7282;
   localparam int DIV9_SHIFT = 16;
   localparam int PROD_W = SUM_W + RECIP_W;

   localparam int FIFO_DEPTH = 8;
   localparam int FIFO_AW = $clog2(FIFO_DEPTH);
   localparam int FIFO_CW = FIFO_AW + 1;

   localparam logic [FW_W-1:0] FRAME_WIDTH_RESET = 12'd640;
   localparam logic [HEIGHT_W-1:0] FRAME_HEIGHT_RESET = 16'd480;

   typedef enum logic {
      CSR_FRAME_WIDTH = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic {
      OP_PIXEL = 1'b0,
      OP_FLUSH = 1'b1
   } op_type;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [CH_COUNT-1:0][SUM_W-1:0] sums_type;

   typedef struct packed {
      logic emit;
      logic interior;
      logic last;
   } ctl_type;

endpackage
`default_nettype wire

[hdl/box_filter_3x3_rgb_core.sv]
// Top level of the streaming 3x3 box filter for three-channel 8-bit pixels.
//
// Pixels enter on the req_ channel in raster order, one transfer per pixel,
// with req_tuser low. Each accepted pixel yields at most the result pixel one
// row and one column behind it on the rsp_ channel. Interior pixels get the
// truncated mean of their 3x3 neighborhood per channel; border pixels pass
// through. After the frame, frame_width+1 transfers with req_tuser high drain
// the remaining results, and rsp_tlast marks the last one of the frame.
// The block takes one transfer per cycle while req_tready is high. A result
// is offered after the line memory read at the transfer edge, the window
// update, the sums and the divide by nine into the result queue. The
// eight-entry result queue absorbs receiver stalls: req_tready drops once
// the queue and the items in flight could fill it, and rises again as
// results are taken. Reset clears the position counters, the window and
// the queue and loads the default frame size of 640 by 480; the line
// memories are not cleared. A write on the csr_ port restarts the frame;
// the user must make it only while idle, as the block has no check for it.
`default_nettype none
module box_filter_3x3_rgb_core (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [bf3_pkg::PIX_W-1:0]         req_tdata,  // blue_in, green_in, red_in
   input  wire logic                              req_tuser,  // operation
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [bf3_pkg::PIX_W-1:0]              rsp_tdata,  // blue_out, green_out, red_out
   output logic                                   rsp_tlast,
   input  wire logic                              csr_we,
   input  wire bf3_pkg::csr_index_type            csr_index,
   input  wire logic [bf3_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   logic [bf3_pkg::FW_W-1:0]     frame_width_ff;
   logic [bf3_pkg::FW_W-1:0]     frame_width_in;
   logic [bf3_pkg::HEIGHT_W-1:0] frame_height_ff;
   logic [bf3_pkg::HEIGHT_W-1:0] frame_height_in;
   logic [bf3_pkg::COL_W-1:0]    in_column_ff;
   logic [bf3_pkg::COL_W-1:0]    in_column_in;
   logic [bf3_pkg::ROW_W-1:0]    in_row_ff;
   logic [bf3_pkg::ROW_W-1:0]    in_row_in;
   logic [bf3_pkg::COL_W-1:0]    out_column_ff;
   logic [bf3_pkg::COL_W-1:0]    out_column_in;
   logic [bf3_pkg::HEIGHT_W-1:0] out_row_ff;
   logic [bf3_pkg::HEIGHT_W-1:0] out_row_in;

   logic [bf3_pkg::WIDTH_W-1:0]  width_eff;
   logic [bf3_pkg::HEIGHT_W-1:0] height_eff;
   logic                         draining;
   logic                         take;
   logic                         emit;
   logic                         interior;
   logic                         last;
   logic [bf3_pkg::WIDTH_W-1:0]  in_col_next;
   logic [bf3_pkg::WIDTH_W-1:0]  out_col_next;
   logic [bf3_pkg::ROW_W-1:0]    out_row_next;
   bf3_pkg::pix_type             pix;
   bf3_pkg::ctl_type             ctl;

   logic                         lb_valid;
   bf3_pkg::ctl_type             lb_ctl;
   bf3_pkg::pix_type             lb_pix;
   bf3_pkg::pix_type             lb_upper;
   bf3_pkg::pix_type             lb_middle;
   logic                         sum_valid;
   bf3_pkg::ctl_type             sum_ctl;
   bf3_pkg::sums_type            sums;
   bf3_pkg::pix_type             center;
   logic [1:0]                   busy_emit;
   logic                         push;
   bf3_pkg::pix_type             push_pix;
   logic                         push_last;
   logic [bf3_pkg::FIFO_CW-1:0]  fifo_count;
   logic [bf3_pkg::FIFO_CW:0]    pending;

   always_comb begin
      if (frame_width_ff == '0) begin
         width_eff = bf3_pkg::WIDTH_W'(1);
      end else if (32'(frame_width_ff) > 32'(bf3_pkg::MAX_WIDTH)) begin
         width_eff = bf3_pkg::WIDTH_W'(bf3_pkg::MAX_WIDTH);
      end else begin
         width_eff = bf3_pkg::WIDTH_W'(frame_width_ff);
      end
      height_eff = (frame_height_ff == '0) ? bf3_pkg::HEIGHT_W'(1) : frame_height_ff;

      pending = (bf3_pkg::FIFO_CW + 1)'(fifo_count)
         + (bf3_pkg::FIFO_CW + 1)'(lb_valid && lb_ctl.emit)
         + (bf3_pkg::FIFO_CW + 1)'(busy_emit[0]) + (bf3_pkg::FIFO_CW + 1)'(busy_emit[1]);
      req_tready = pending < (bf3_pkg::FIFO_CW + 1)'(bf3_pkg::FIFO_DEPTH);

      draining = in_row_ff >= bf3_pkg::ROW_W'(height_eff);
      take = req_tvalid && req_tready && (draining || (req_tuser != bf3_pkg::OP_FLUSH));
      pix = draining ? '0 : req_tdata;

      in_col_next = bf3_pkg::WIDTH_W'(in_column_ff) + 1'b1;
      out_col_next = bf3_pkg::WIDTH_W'(out_column_ff) + 1'b1;
      out_row_next = bf3_pkg::ROW_W'(out_row_ff) + 1'b1;

      emit = (in_row_ff >= bf3_pkg::ROW_W'(2))
         || ((in_row_ff == bf3_pkg::ROW_W'(1)) && (in_column_ff != '0));
      interior = (out_row_ff != '0) && (out_row_next < bf3_pkg::ROW_W'(height_eff))
         && (out_column_ff != '0) && (out_col_next < width_eff);
      last = (out_row_next >= bf3_pkg::ROW_W'(height_eff)) && (out_col_next >= width_eff);

      ctl.emit = emit;
      ctl.interior = interior;
      ctl.last = last;
   end

   always_comb begin
      frame_width_in = frame_width_ff;
      frame_height_in = frame_height_ff;
      in_column_in = in_column_ff;
      in_row_in = in_row_ff;
      out_column_in = out_column_ff;
      out_row_in = out_row_ff;
      if (csr_we) begin
         case (csr_index)
            bf3_pkg::CSR_FRAME_WIDTH: frame_width_in = csr_wdata[bf3_pkg::FW_W-1:0];
            bf3_pkg::CSR_FRAME_HEIGHT: frame_height_in = csr_wdata[bf3_pkg::HEIGHT_W-1:0];
            default: frame_width_in = frame_width_ff;
         endcase
         in_column_in = '0;
         in_row_in = '0;
         out_column_in = '0;
         out_row_in = '0;
      end else if (take) begin
         if (in_col_next >= width_eff) begin
            in_column_in = '0;
            in_row_in = in_row_ff + 1'b1;
         end else begin
            in_column_in = in_col_next[bf3_pkg::COL_W-1:0];
         end
         if (emit) begin
            if (out_col_next >= width_eff) begin
               out_column_in = '0;
               out_row_in = out_row_next[bf3_pkg::HEIGHT_W-1:0];
            end else begin
               out_column_in = out_col_next[bf3_pkg::COL_W-1:0];
            end
            if (last) begin
               in_column_in = '0;
               in_row_in = '0;
               out_column_in = '0;
               out_row_in = '0;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff <= bf3_pkg::FRAME_WIDTH_RESET;
         frame_height_ff <= bf3_pkg::FRAME_HEIGHT_RESET;
         in_column_ff <= '0;
         in_row_ff <= '0;
         out_column_ff <= '0;
         out_row_ff <= '0;
      end else begin
         frame_width_ff <= frame_width_in;
         frame_height_ff <= frame_height_in;
         in_column_ff <= in_column_in;
         in_row_ff <= in_row_in;
         out_column_ff <= out_column_in;
         out_row_ff <= out_row_in;
      end
   end

   bf3_line_buf u_line_buf (
      .clock      (clock),
      .reset      (reset),
      .rd_en      (take),
      .rd_col     (in_column_ff),
      .rd_pix     (pix),
      .rd_ctl     (ctl),
      .out_valid  (lb_valid),
      .out_ctl    (lb_ctl),
      .out_pix    (lb_pix),
      .out_upper  (lb_upper),
      .out_middle (lb_middle)
   );

   bf3_window u_window (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (lb_valid),
      .in_ctl    (lb_ctl),
      .in_pix    (lb_pix),
      .in_upper  (lb_upper),
      .in_middle (lb_middle),
      .sum_valid (sum_valid),
      .sum_ctl   (sum_ctl),
      .sums      (sums),
      .center    (center),
      .busy_emit (busy_emit)
   );

   bf3_mean u_mean (
      .in_valid  (sum_valid),
      .in_ctl    (sum_ctl),
      .in_sums   (sums),
      .in_center (center),
      .push      (push),
      .push_pix  (push_pix),
      .push_last (push_last)
   );

   bf3_out_fifo u_out_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_pix  (push_pix),
      .push_last (push_last),
      .pop_ready (rsp_tready),
      .out_valid (rsp_tvalid),
      .out_pix   (rsp_tdata),
      .out_last  (rsp_tlast),
      .count     (fifo_count)
   );

endmodule
`default_nettype wire

[hdl/bf3_line_buf.sv]
// Two line memories holding the previous two rows, with write-back forwarding.
`default_nettype none
module bf3_line_buf (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire logic                    rd_en,
   input  wire logic [bf3_pkg::COL_W-1:0] rd_col,
   input  wire bf3_pkg::pix_type        rd_pix,
   input  wire bf3_pkg::ctl_type        rd_ctl,
   output logic                         out_valid,
   output bf3_pkg::ctl_type             out_ctl,
   output bf3_pkg::pix_type             out_pix,
   output bf3_pkg::pix_type             out_upper,
   output bf3_pkg::pix_type             out_middle
);

   bf3_pkg::pix_type upper_mem [bf3_pkg::MAX_WIDTH];
   bf3_pkg::pix_type middle_mem [bf3_pkg::MAX_WIDTH];

   logic                      valid_ff;
   logic [bf3_pkg::COL_W-1:0] col_ff;
   bf3_pkg::pix_type          pix_ff;
   bf3_pkg::ctl_type          ctl_ff;
   bf3_pkg::pix_type          rd_upper_ff;
   bf3_pkg::pix_type          rd_middle_ff;
   logic                      fwd_ff;
   bf3_pkg::pix_type          fwd_upper_ff;
   bf3_pkg::pix_type          fwd_middle_ff;
   logic                      fwd_in;
   bf3_pkg::pix_type          upper_eff;
   bf3_pkg::pix_type          middle_eff;

   always_comb begin
      upper_eff = fwd_ff ? fwd_upper_ff : rd_upper_ff;
      middle_eff = fwd_ff ? fwd_middle_ff : rd_middle_ff;
      fwd_in = valid_ff && (col_ff == rd_col);
   end

   always_ff @(posedge clock) begin
      if (valid_ff) begin
         upper_mem[col_ff] <= middle_eff;
         middle_mem[col_ff] <= pix_ff;
      end
      if (rd_en) begin
         rd_upper_ff <= upper_mem[rd_col];
         rd_middle_ff <= middle_mem[rd_col];
         fwd_upper_ff <= middle_eff;
         fwd_middle_ff <= pix_ff;
         col_ff <= rd_col;
         pix_ff <= rd_pix;
         ctl_ff <= rd_ctl;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         fwd_ff <= 1'b0;
      end else begin
         valid_ff <= rd_en;
         if (rd_en) begin
            fwd_ff <= fwd_in;
         end
      end
   end

   assign out_valid = valid_ff;
   assign out_ctl = ctl_ff;
   assign out_pix = pix_ff;
   assign out_upper = upper_eff;
   assign out_middle = middle_eff;

endmodule
`default_nettype wire

[hdl/bf3_window.sv]
// The 3x3 window registers and the registered per-channel window sums.
`default_nettype none
module bf3_window (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   input  wire bf3_pkg::ctl_type in_ctl,
   input  wire bf3_pkg::pix_type in_pix,
   input  wire bf3_pkg::pix_type in_upper,
   input  wire bf3_pkg::pix_type in_middle,
   output logic                  sum_valid,
   output bf3_pkg::ctl_type      sum_ctl,
   output bf3_pkg::sums_type     sums,
   output bf3_pkg::pix_type      center,
   output logic [1:0]            busy_emit
);

   bf3_pkg::pix_type [bf3_pkg::WIN_COUNT-1:0] window_ff;
   bf3_pkg::pix_type [bf3_pkg::WIN_COUNT-1:0] window_in;
   logic                  win_valid_ff;
   bf3_pkg::ctl_type      win_ctl_ff;
   logic                  sum_valid_ff;
   bf3_pkg::ctl_type      sum_ctl_ff;
   bf3_pkg::sums_type     sums_ff;
   bf3_pkg::sums_type     sums_in;
   bf3_pkg::pix_type      center_ff;

   always_comb begin
      window_in = window_ff;
      if (in_valid) begin
         for (int r = 0; r < 3; r++) begin
            window_in[r * 3] = window_ff[r * 3 + 1];
            window_in[r * 3 + 1] = window_ff[r * 3 + 2];
         end
         window_in[2] = in_upper;
         window_in[5] = in_middle;
         window_in[8] = in_pix;
      end
   end

   always_comb begin
      sums_in = '0;
      for (int ch = 0; ch < bf3_pkg::CH_COUNT; ch++) begin
         for (int k = 0; k < bf3_pkg::WIN_COUNT; k++) begin
            sums_in[ch] = sums_in[ch]
               + bf3_pkg::SUM_W'(window_ff[k][ch * bf3_pkg::CH_W +: bf3_pkg::CH_W]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         window_ff <= '0;
         win_valid_ff <= 1'b0;
         sum_valid_ff <= 1'b0;
      end else begin
         window_ff <= window_in;
         win_valid_ff <= in_valid;
         sum_valid_ff <= win_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid) begin
         win_ctl_ff <= in_ctl;
      end
      if (win_valid_ff) begin
         sum_ctl_ff <= win_ctl_ff;
         sums_ff <= sums_in;
         center_ff <= window_ff[4];
      end
   end

   assign sum_valid = sum_valid_ff;
   assign sum_ctl = sum_ctl_ff;
   assign sums = sums_ff;
   assign center = center_ff;
   assign busy_emit = {sum_valid_ff && sum_ctl_ff.emit, win_valid_ff && win_ctl_ff.emit};

endmodule
`default_nettype wire

[hdl/bf3_mean.sv]
// Division of the window sums by nine and selection between mean and center pixel.
`default_nettype none
module bf3_mean (
   input  wire logic              in_valid,
   input  wire bf3_pkg::ctl_type  in_ctl,
   input  wire bf3_pkg::sums_type in_sums,
   input  wire bf3_pkg::pix_type  in_center,
   output logic                   push,
   output bf3_pkg::pix_type       push_pix,
   output logic                   push_last
);

   logic [bf3_pkg::PROD_W-1:0] prod;
   bf3_pkg::pix_type           mean_pix;

   always_comb begin
      prod = '0;
      for (int ch = 0; ch < bf3_pkg::CH_COUNT; ch++) begin
         prod = bf3_pkg::PROD_W'(in_sums[ch]) * bf3_pkg::PROD_W'(bf3_pkg::DIV9_RECIP);
         mean_pix[ch * bf3_pkg::CH_W +: bf3_pkg::CH_W] = prod[bf3_pkg::DIV9_SHIFT +: bf3_pkg::CH_W];
      end
      push = in_valid && in_ctl.emit;
      push_pix = in_ctl.interior ? mean_pix : in_center;
      push_last = in_ctl.last;
   end

endmodule
`default_nettype wire

[hdl/bf3_out_fifo.sv]
// Small result queue that decouples the pipeline from the receiver.
`default_nettype none
module bf3_out_fifo (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      push,
   input  wire bf3_pkg::pix_type          push_pix,
   input  wire logic                      push_last,
   input  wire logic                      pop_ready,
   output logic                           out_valid,
   output bf3_pkg::pix_type               out_pix,
   output logic                           out_last,
   output logic [bf3_pkg::FIFO_CW-1:0]    count
);

   logic [bf3_pkg::FIFO_DEPTH-1:0][bf3_pkg::PIX_W:0] entry_ff;
   logic [bf3_pkg::FIFO_AW-1:0] wr_ptr_ff;
   logic [bf3_pkg::FIFO_AW-1:0] rd_ptr_ff;
   logic [bf3_pkg::FIFO_CW-1:0] count_ff;
   logic                        pop;

   assign out_valid = count_ff != '0;
   assign pop = out_valid && pop_ready;
   assign out_pix = entry_ff[rd_ptr_ff][bf3_pkg::PIX_W-1:0];
   assign out_last = entry_ff[rd_ptr_ff][bf3_pkg::PIX_W];
   assign count = count_ff;

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= {push_last, push_pix};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         case ({push, pop})
            2'b10: count_ff <= count_ff + 1'b1;
            2'b01: count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule
`default_nettype wire
